/* rtl/parity_split_sort_check_defines.svh */
// Assertion macros shared by the parity split sort check RTL.
`ifndef PARITY_SPLIT_SORT_CHECK_DEFINES_SVH
`define PARITY_SPLIT_SORT_CHECK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pst_pkg.sv */
// Types and constants of the parity split sort check block.
`timescale 1ns / 1ps
package pst_pkg;
    localparam int MAX_ITEMS_DEF = 256;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 8;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_req;

    typedef struct packed {
        logic             sorted_ok;
        logic [IDX_W-1:0] first_bad_index;
        logic             overflow;
    } t_result;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } t_cell_data;
endpackage

/* rtl/parity_split_sort_check.sv */
// Top level of the parity split sort check block.
`timescale 1ns / 1ps
// Usage:
//   Requests come in on i_req (value, last) and are taken at a clock edge with
//   start high and busy low. Values at even list positions are inserted into
//   one sorted chain of cells, values at odd positions into another; each
//   insertion is stored at the accepting edge, so a list streams in at one
//   request per cycle while busy stays low.
//   A request with last set starts the scan: busy goes high and both chains
//   shift toward cell 0 one step per cycle, checking two adjacent pairs of the
//   interleaved list each step; it stops early at the first out-of-order pair.
//   The result is presented on o_result with o_valid high for exactly one
//   cycle, the cycle after the scan ends; busy drops in that same cycle, so a
//   new list may start right away. The receiver cannot stall the result.
//   Items beyond MAX_ITEMS are dropped and reported through the overflow bit;
//   their last mark still closes the list.
//   Reset (synchronous, active low) empties both chains, clears the item
//   count and the overflow flag, and returns the block to idle.
//   After each result the block clears itself the same way.
module parity_split_sort_check #(
    parameter int MAX_ITEMS = pst_pkg::MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pst_pkg::t_req    i_req,
    output logic             o_valid,
    output pst_pkg::t_result o_result
);
    import pst_pkg::*;
    `include "parity_split_sort_check_defines.svh"

    localparam int HALF  = (MAX_ITEMS + 1) / 2;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int K_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    logic [CNT_W-1:0] r_rem;      // interleaved entries not yet passed by the scan
    logic [CNT_W-1:0] n_rem;
    logic [K_W-1:0]   r_k;        // interleaved index of the current even head
    logic [K_W-1:0]   n_k;
    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_result;
    t_result          n_result;

    t_cell_ctrl        w_even_ctrl;
    t_cell_ctrl        w_odd_ctrl;
    logic [DATA_W-1:0] w_e0;
    logic [DATA_W-1:0] w_e1;
    logic [DATA_W-1:0] w_o0;
    logic [DATA_W-1:0] w_o1;

    logic w_accept;
    logic w_full;
    logic w_bad0;
    logic w_bad1;
    logic w_done;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count >= CNT_W'(MAX_ITEMS));

    // pair (2j, 2j+1) is even head vs odd head; pair (2j+1, 2j+2) is odd head
    // vs the even cell behind the head
    assign w_bad0 = (r_rem >= CNT_W'(2)) && (w_e0 > w_o0);
    assign w_bad1 = (r_rem >= CNT_W'(3)) && (w_o0 > w_e1);
    assign w_done = w_bad0 || w_bad1 || (r_rem <= CNT_W'(3));

    pst_chain #(.DEPTH(HALF)) u_even (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_even_ctrl),
        .o_head0 (w_e0),
        .o_head1 (w_e1)
    );

    pst_chain #(.DEPTH(HALF)) u_odd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_odd_ctrl),
        .o_head0 (w_o0),
        .o_head1 (w_o1)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rem       = r_rem;
        n_k         = r_k;
        n_out_valid = 1'b0;
        n_result    = r_result;
        w_even_ctrl = '{op: OP_HOLD, value: i_req.value};
        w_odd_ctrl  = '{op: OP_HOLD, value: i_req.value};

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        if (r_count[0]) begin
                            w_odd_ctrl.op = OP_INSERT;
                        end else begin
                            w_even_ctrl.op = OP_INSERT;
                        end
                    end
                    if (i_req.last) begin
                        n_state = ST_SCAN;
                        n_rem   = n_count;
                        n_k     = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (w_done) begin
                    n_out_valid              = 1'b1;
                    n_result.sorted_ok       = !(w_bad0 || w_bad1);
                    n_result.overflow        = r_ovf;
                    if (w_bad0) begin
                        n_result.first_bad_index = r_k[IDX_W-1:0];
                    end else if (w_bad1) begin
                        n_result.first_bad_index = r_k[IDX_W-1:0] + IDX_W'(1);
                    end else begin
                        n_result.first_bad_index = '0;
                    end
                    w_even_ctrl.op = OP_CLEAR;
                    w_odd_ctrl.op  = OP_CLEAR;
                    n_count        = '0;
                    n_ovf          = 1'b0;
                    n_state        = ST_IDLE;
                end else begin
                    w_even_ctrl.op = OP_SHIFT;
                    w_odd_ctrl.op  = OP_SHIFT;
                    n_rem          = r_rem - CNT_W'(2);
                    n_k            = r_k + K_W'(2);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_k      <= n_k;
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // the second odd head is not part of any checked pair
    logic w_unused;
    assign w_unused = ^w_o1;

    `PST_ASSERT_NEXT(a_result_after_scan, (r_state == ST_SCAN) && w_done, o_valid && !busy, "scan end did not give a result")
    `PST_ASSERT_NOW(a_ok_index_zero, o_valid && o_result.sorted_ok, o_result.first_bad_index == '0, "sorted result with nonzero index")
    `PST_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ITEMS), "item count beyond capacity")
    `PST_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe held over two cycles")
endmodule

/* rtl/pst_cell.sv */
// One cell of a sorted insertion chain.
`timescale 1ns / 1ps
module pst_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pst_pkg::t_cell_ctrl i_ctrl,
    input  pst_pkg::t_cell_data i_prev,
    input  logic                i_prev_gt,
    input  pst_pkg::t_cell_data i_next,
    output pst_pkg::t_cell_data o_data,
    output logic                o_gt
);
    import pst_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // empty cell counts as larger than any value
    assign o_gt   = !r_valid || (r_value > i_ctrl.value);
    assign o_data = '{valid: r_valid, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (o_gt) begin
                    if (i_prev_gt) begin
                        n_valid = i_prev.valid;
                        n_value = i_prev.value;
                    end else begin
                        n_valid = 1'b1;
                        n_value = i_ctrl.value;
                    end
                end
            end
            OP_SHIFT: begin
                n_valid = i_next.valid;
                n_value = i_next.value;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule

/* rtl/pst_chain.sv */
// Row of insertion cells holding one sorted half of the list.
`timescale 1ns / 1ps
module pst_chain #(
    parameter int DEPTH = (pst_pkg::MAX_ITEMS_DEF + 1) / 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pst_pkg::t_cell_ctrl       i_ctrl,
    output logic [pst_pkg::DATA_W-1:0] o_head0,
    output logic [pst_pkg::DATA_W-1:0] o_head1
);
    import pst_pkg::*;

    t_cell_data w_data [DEPTH];
    logic       w_gt   [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_data w_prev;
        t_cell_data w_next;
        logic       w_prev_gt;

        if (gi == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_mid
            assign w_prev    = w_data[gi-1];
            assign w_prev_gt = w_gt[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_data[gi+1];
        end

        pst_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (i_ctrl),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_data    (w_data[gi]),
            .o_gt      (w_gt[gi])
        );
    end

    assign o_head0 = w_data[0].value;

    if (DEPTH > 1) begin : g_head1
        assign o_head1 = w_data[1].value;
    end else begin : g_no_head1
        assign o_head1 = '1;
    end
endmodule
